/* src/dmes_pkg.sv */
package dmes_pkg;

	localparam int COORD_BITS = 20;
	localparam int MASS_BITS  = 12;
	localparam int QDEPTH     = 4;

	localparam int ACC_BITS   = 64;
	localparam int SAT_BITS   = 128;
	localparam int DISP_BITS  = COORD_BITS + 1;
	localparam int XPROD_BITS = COORD_BITS + DISP_BITS;
	localparam int CROSS_BITS = XPROD_BITS + 1;
	localparam int SQ_BITS    = 2 * DISP_BITS;
	localparam int MOM_BITS   = DISP_BITS + MASS_BITS + 1;
	localparam int ANG_BITS   = CROSS_BITS + MASS_BITS + 1;
	localparam int EN_BITS    = SQ_BITS + MASS_BITS;

	localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
	localparam logic signed [SAT_BITS-1:0] SAT_MAX = SAT_BITS'(ACC_MAX);
	localparam logic signed [SAT_BITS-1:0] SAT_NMAX = -SAT_MAX;

	typedef struct packed {
		logic [MASS_BITS-1:0]         mass;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] start_z;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic signed [COORD_BITS-1:0] end_z;
		logic                         is_last;
	} in_t;

	typedef struct packed {
		logic signed [ACC_BITS-1:0] momentum_x;
		logic signed [ACC_BITS-1:0] momentum_y;
		logic signed [ACC_BITS-1:0] momentum_z;
		logic signed [ACC_BITS-1:0] angular_x;
		logic signed [ACC_BITS-1:0] angular_y;
		logic signed [ACC_BITS-1:0] angular_z;
		logic [ACC_BITS-2:0]        energy;
		logic                       overflow;
	} out_t;

	typedef struct packed {
		logic [MASS_BITS-1:0]         mass;
		logic signed [DISP_BITS-1:0]  dx;
		logic signed [DISP_BITS-1:0]  dy;
		logic signed [DISP_BITS-1:0]  dz;
		logic signed [CROSS_BITS-1:0] cx;
		logic signed [CROSS_BITS-1:0] cy;
		logic signed [CROSS_BITS-1:0] cz;
		logic [SQ_BITS-1:0]           sq;
		logic                         is_last;
	} work_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic                       sat;
		logic signed [ACC_BITS-1:0] val;
	} clamp_s_t;

	typedef struct packed {
		logic                sat;
		logic [ACC_BITS-1:0] val;
	} clamp_u_t;

	// product term clamp: magnitude above the positive limit saturates
	function automatic clamp_s_t clamp_prod_s(input logic signed [SAT_BITS-1:0] p);
		clamp_s_t r;
		r.sat = 1'b0;
		r.val = p[ACC_BITS-1:0];
		if (p > SAT_MAX) begin
			r.sat = 1'b1;
			r.val = ACC_MAX;
		end else if (p < SAT_NMAX) begin
			r.sat = 1'b1;
			r.val = ACC_MIN;
		end
		return r;
	endfunction

	function automatic clamp_s_t clamp_sum_s(input logic signed [ACC_BITS-1:0] a,
			input logic signed [ACC_BITS-1:0] b);
		logic signed [ACC_BITS:0] s;
		clamp_s_t r;
		s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
		r.sat = s[ACC_BITS] ^ s[ACC_BITS-1];
		r.val = s[ACC_BITS-1:0];
		if (r.sat) begin
			r.val = s[ACC_BITS] ? ACC_MIN : ACC_MAX;
		end
		return r;
	endfunction

	function automatic clamp_u_t clamp_u(input logic [SAT_BITS-1:0] p);
		clamp_u_t r;
		r.sat = |p[SAT_BITS-1:ACC_BITS];
		r.val = r.sat ? {ACC_BITS{1'b1}} : p[ACC_BITS-1:0];
		return r;
	endfunction

endpackage

/* src/dmes_front.sv */
module dmes_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dmes_pkg::in_t     item,
	input  dmes_pkg::q_stat_t q_stat,
	output logic              full,
	output logic              q_push,
	output dmes_pkg::work_t   q_wdata
);
	import dmes_pkg::*;

	logic valid_s1, valid_s2, adv_s1, adv_s2, accept;
	logic [MASS_BITS-1:0] mass_s1;
	logic signed [COORD_BITS-1:0] sx_s1, sy_s1, sz_s1;
	logic signed [DISP_BITS-1:0] dx_s1, dy_s1, dz_s1;
	logic last_s1;
	work_t work_s2;
	logic signed [XPROD_BITS-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
	logic signed [SQ_BITS-1:0] qx, qy, qz;

	assign adv_s2  = !valid_s2 || !q_stat.full;
	assign adv_s1  = !valid_s1 || adv_s2;
	assign full    = !adv_s1;
	assign accept  = push && !full;
	assign q_push  = valid_s2 && !q_stat.full;
	assign q_wdata = work_s2;

	assign p_yz = XPROD_BITS'(sy_s1) * XPROD_BITS'(dz_s1);
	assign p_zy = XPROD_BITS'(sz_s1) * XPROD_BITS'(dy_s1);
	assign p_zx = XPROD_BITS'(sz_s1) * XPROD_BITS'(dx_s1);
	assign p_xz = XPROD_BITS'(sx_s1) * XPROD_BITS'(dz_s1);
	assign p_xy = XPROD_BITS'(sx_s1) * XPROD_BITS'(dy_s1);
	assign p_yx = XPROD_BITS'(sy_s1) * XPROD_BITS'(dx_s1);
	assign qx   = SQ_BITS'(dx_s1) * SQ_BITS'(dx_s1);
	assign qy   = SQ_BITS'(dy_s1) * SQ_BITS'(dy_s1);
	assign qz   = SQ_BITS'(dz_s1) * SQ_BITS'(dz_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= accept;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// displacement
	always_ff @(posedge clk) begin
		if (adv_s1 && accept) begin
			mass_s1 <= item.mass;
			sx_s1   <= item.start_x;
			sy_s1   <= item.start_y;
			sz_s1   <= item.start_z;
			dx_s1   <= DISP_BITS'(item.end_x) - DISP_BITS'(item.start_x);
			dy_s1   <= DISP_BITS'(item.end_y) - DISP_BITS'(item.start_y);
			dz_s1   <= DISP_BITS'(item.end_z) - DISP_BITS'(item.start_z);
			last_s1 <= item.is_last;
		end
	end

	// cross product and squared length
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			work_s2.mass    <= mass_s1;
			work_s2.dx      <= dx_s1;
			work_s2.dy      <= dy_s1;
			work_s2.dz      <= dz_s1;
			work_s2.cx      <= CROSS_BITS'(p_yz) - CROSS_BITS'(p_zy);
			work_s2.cy      <= CROSS_BITS'(p_zx) - CROSS_BITS'(p_xz);
			work_s2.cz      <= CROSS_BITS'(p_xy) - CROSS_BITS'(p_yx);
			work_s2.sq      <= $unsigned(qx) + $unsigned(qy) + $unsigned(qz);
			work_s2.is_last <= last_s1;
		end
	end

endmodule

/* src/dmes_queue.sv */
module dmes_queue #(
	parameter int DEPTH = dmes_pkg::QDEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_push,
	input  dmes_pkg::work_t   q_wdata,
	input  logic              q_pop,
	output dmes_pkg::q_stat_t q_stat,
	output dmes_pkg::work_t   q_rdata
);
	import dmes_pkg::*;

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	work_t mem [DEPTH];
	work_t rdata_q;
	logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == CNTW'(DEPTH));
	assign q_rdata      = rdata_q;

	always_ff @(posedge clk) begin
		if (q_push) begin
			mem[wr_ptr_q] <= q_wdata;
		end
		if (q_pop) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({q_push, q_pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

/* src/dmes_back.sv */
module dmes_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dmes_pkg::q_stat_t q_stat,
	input  dmes_pkg::work_t   q_rdata,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output dmes_pkg::out_t    result
);
	import dmes_pkg::*;

	logic valid_s3, valid_s4, adv_s3, adv_s4, commit;
	logic signed [MOM_BITS-1:0] pm_s4 [3];
	logic signed [ANG_BITS-1:0] pa_s4 [3];
	logic [EN_BITS-1:0] pe_s4;
	logic last_s4;

	logic signed [ACC_BITS-1:0] mom_q [3];
	logic signed [ACC_BITS-1:0] ang_q [3];
	logic [ACC_BITS-1:0] en_q;
	logic sat_q;
	logic out_valid_q;
	out_t out_q;

	clamp_s_t mt [3];
	clamp_s_t ms [3];
	clamp_s_t at [3];
	clamp_s_t as_ [3];
	clamp_u_t et, es;
	logic signed [ACC_BITS-1:0] mom_n [3];
	logic signed [ACC_BITS-1:0] ang_n [3];
	logic sat_n;
	logic signed [MASS_BITS:0] mass_sg;

	assign commit = valid_s4 && (!last_s4 || !out_valid_q || pop);
	assign adv_s4 = !valid_s4 || commit;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign q_pop  = !q_stat.empty && adv_s3;
	assign empty  = !out_valid_q;
	assign result = out_q;
	assign mass_sg = $signed({1'b0, q_rdata.mass});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s3) begin
				valid_s3 <= q_pop;
			end
			if (adv_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// mass products
	always_ff @(posedge clk) begin
		if (adv_s4 && valid_s3) begin
			pm_s4[0] <= MOM_BITS'(mass_sg) * MOM_BITS'(q_rdata.dx);
			pm_s4[1] <= MOM_BITS'(mass_sg) * MOM_BITS'(q_rdata.dy);
			pm_s4[2] <= MOM_BITS'(mass_sg) * MOM_BITS'(q_rdata.dz);
			pa_s4[0] <= ANG_BITS'(mass_sg) * ANG_BITS'(q_rdata.cx);
			pa_s4[1] <= ANG_BITS'(mass_sg) * ANG_BITS'(q_rdata.cy);
			pa_s4[2] <= ANG_BITS'(mass_sg) * ANG_BITS'(q_rdata.cz);
			pe_s4    <= EN_BITS'(q_rdata.mass) * EN_BITS'(q_rdata.sq);
			last_s4  <= q_rdata.is_last;
		end
	end

	// saturating accumulate
	always_comb begin
		sat_n = sat_q;
		for (int i = 0; i < 3; i++) begin
			mt[i]    = clamp_prod_s(SAT_BITS'(pm_s4[i]));
			ms[i]    = clamp_sum_s(mom_q[i], mt[i].val);
			at[i]    = clamp_prod_s(SAT_BITS'(pa_s4[i]));
			as_[i]   = clamp_sum_s(ang_q[i], at[i].val);
			mom_n[i] = ms[i].val;
			ang_n[i] = as_[i].val;
			sat_n    = sat_n | mt[i].sat | ms[i].sat | at[i].sat | as_[i].sat;
		end
		et    = clamp_u(SAT_BITS'(pe_s4));
		es    = clamp_u(SAT_BITS'(en_q) + SAT_BITS'(et.val));
		sat_n = sat_n | et.sat | es.sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				mom_q[i] <= '0;
				ang_q[i] <= '0;
			end
			en_q        <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit && last_s4) begin
				for (int i = 0; i < 3; i++) begin
					mom_q[i] <= '0;
					ang_q[i] <= '0;
				end
				en_q        <= '0;
				sat_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (commit) begin
					for (int i = 0; i < 3; i++) begin
						mom_q[i] <= mom_n[i];
						ang_q[i] <= ang_n[i];
					end
					en_q  <= es.val;
					sat_q <= sat_n;
				end
				if (pop) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && last_s4) begin
			out_q.momentum_x <= mom_n[0];
			out_q.momentum_y <= mom_n[1];
			out_q.momentum_z <= mom_n[2];
			out_q.angular_x  <= ang_n[0];
			out_q.angular_y  <= ang_n[1];
			out_q.angular_z  <= ang_n[2];
			out_q.energy     <= es.val[ACC_BITS-1:1];
			out_q.overflow   <= sat_n;
		end
	end

endmodule

/* src/displacement_momentum_energy_sum.sv */
// channel   ports                  handshake
// request   item (dmes_pkg::in_t)  push / full, taken when push && !full
// result    result (dmes_pkg::out_t) empty / pop, taken when pop && !empty
//
// one request per cycle sustained while full is low; the accumulate stage adds one
// particle per cycle unless a last request waits for a pop; a result can be popped
// after the two front stages, queue write, queue read, mass products and accumulate
// reset clears the sums, the overflow flag, the queue and all valid bits
// full rises when the queue and both front stages are occupied
// a last request waits at the accumulate stage while an earlier result is not popped
module displacement_momentum_energy_sum #(
	parameter int QUEUE_DEPTH = dmes_pkg::QDEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  dmes_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output dmes_pkg::out_t result
);
	import dmes_pkg::*;

	logic q_push, q_pop;
	work_t q_wdata, q_rdata;
	q_stat_t q_stat;

	dmes_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.q_stat  (q_stat),
		.full    (full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	dmes_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.q_wdata (q_wdata),
		.q_pop   (q_pop),
		.q_stat  (q_stat),
		.q_rdata (q_rdata)
	);

	dmes_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	a_no_push_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_push)
		else $error("queue written while full");

	a_no_pop_when_empty : assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !q_pop)
		else $error("queue read while empty");

	a_full_means_queue_full : assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_stat.full)
		else $error("input stalled while queue has room");

endmodule

/* verif/displacement_momentum_energy_sum_test.sv */
module displacement_momentum_energy_sum_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dmes_pkg::*;

	localparam int MISMATCH_SHOWN = 10;
	localparam int SAT_SET_LEN    = 1400;
	localparam int STALL_CYCLES   = 300;
	localparam int DRAIN_CYCLES   = 20;

	localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [MASS_BITS-1:0]         M_MAX = '1;
	localparam logic signed [127:0]          WIDE_MAX = 128'sd9223372036854775807;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	in_t  item;
	logic empty;
	logic pop = 1'b0;
	out_t result;

	longint      mom_sum[3];
	longint      ang_sum[3];
	logic [63:0] energy_sum;
	logic        clamp_seen;
	out_t        sums_due[$];
	int          mismatches = 0;
	int          send_idle_pct = 8;
	int          recv_idle_pct = 60;
	int          stall_request = 0;
	int          stall_left = 0;

	displacement_momentum_energy_sum DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	function automatic void clear_sums();
		for (int i = 0; i < 3; i++) begin
			mom_sum[i] = 0;
			ang_sum[i] = 0;
		end
		energy_sum = '0;
		clamp_seen = 1'b0;
	endfunction

	function automatic longint clamp_product(input logic signed [127:0] v);
		if (v > WIDE_MAX || v < -WIDE_MAX) begin
			clamp_seen = 1'b1;
			return (v < 0) ? ACC_MIN : ACC_MAX;
		end
		return longint'(v);
	endfunction

	function automatic longint clamp_sum(input longint a, input longint b);
		logic signed [127:0] s;
		s = 128'(a) + 128'(b);
		if (s > WIDE_MAX) begin
			clamp_seen = 1'b1;
			return ACC_MAX;
		end
		if (s < -WIDE_MAX - 1) begin
			clamp_seen = 1'b1;
			return ACC_MIN;
		end
		return longint'(s);
	endfunction

	function automatic logic [63:0] clamp_unsigned(input logic [127:0] v);
		if (v[127:64] != '0) begin
			clamp_seen = 1'b1;
			return '1;
		end
		return v[63:0];
	endfunction

	function automatic void accumulate_particle(input in_t p);
		longint      st[3];
		longint      fin[3];
		longint      dv[3];
		longint      cr[3];
		longint      m;
		logic [63:0] sq;
		out_t        r;
		st[0] = longint'(p.start_x);
		st[1] = longint'(p.start_y);
		st[2] = longint'(p.start_z);
		fin[0] = longint'(p.end_x);
		fin[1] = longint'(p.end_y);
		fin[2] = longint'(p.end_z);
		m = longint'(p.mass);
		sq = '0;
		for (int i = 0; i < 3; i++) begin
			dv[i] = fin[i] - st[i];
			sq = sq + dv[i] * dv[i];
		end
		cr[0] = st[1] * dv[2] - st[2] * dv[1];
		cr[1] = st[2] * dv[0] - st[0] * dv[2];
		cr[2] = st[0] * dv[1] - st[1] * dv[0];
		for (int i = 0; i < 3; i++) begin
			mom_sum[i] = clamp_sum(mom_sum[i], clamp_product(128'(dv[i]) * 128'(m)));
			ang_sum[i] = clamp_sum(ang_sum[i], clamp_product(128'(cr[i]) * 128'(m)));
		end
		energy_sum = clamp_unsigned(128'(energy_sum)
			+ 128'(clamp_unsigned(128'(sq) * 128'(m))));
		if (p.is_last) begin
			r.momentum_x = mom_sum[0];
			r.momentum_y = mom_sum[1];
			r.momentum_z = mom_sum[2];
			r.angular_x  = ang_sum[0];
			r.angular_y  = ang_sum[1];
			r.angular_z  = ang_sum[2];
			r.energy     = energy_sum[63:1];
			r.overflow   = clamp_seen;
			sums_due.push_back(r);
			clear_sums();
		end
	endfunction

	function automatic void note_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MISMATCH_SHOWN)
				$display("%0t: %s expected %h got %h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk) begin
		out_t want;
		if (arst_n && pop && !empty) begin
			if (sums_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MISMATCH_SHOWN)
					$display("%0t: result with none expected", $time);
			end else begin
				want = sums_due.pop_front();
				note_field("momentum_x", want.momentum_x, result.momentum_x);
				note_field("momentum_y", want.momentum_y, result.momentum_y);
				note_field("momentum_z", want.momentum_z, result.momentum_z);
				note_field("angular_x", want.angular_x, result.angular_x);
				note_field("angular_y", want.angular_y, result.angular_y);
				note_field("angular_z", want.angular_z, result.angular_z);
				note_field("energy", 64'(want.energy), 64'(result.energy));
				note_field("overflow", 64'(want.overflow), 64'(result.overflow));
			end
		end
	end

	// result side: random gaps, or a long hold-off when asked
	always @(posedge clk) begin
		if (stall_request > 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// push stays high after a request so back-to-back requests need no second update
	task automatic send_particle(input in_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= p;
		do @(posedge clk); while (full);
		accumulate_particle(p);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sums_due.size() != 0) @(posedge clk);
	endtask

	function automatic in_t particle(input logic [MASS_BITS-1:0] m,
			input logic signed [COORD_BITS-1:0] sx, input logic signed [COORD_BITS-1:0] sy,
			input logic signed [COORD_BITS-1:0] sz, input logic signed [COORD_BITS-1:0] ex,
			input logic signed [COORD_BITS-1:0] ey, input logic signed [COORD_BITS-1:0] ez,
			input logic last);
		in_t p;
		p.mass    = m;
		p.start_x = sx;
		p.start_y = sy;
		p.start_z = sz;
		p.end_x   = ex;
		p.end_y   = ey;
		p.end_z   = ez;
		p.is_last = last;
		return p;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] random_coord();
		case ($urandom_range(5))
			0: return C_MIN;
			1: return C_MAX;
			2: return COORD_BITS'($urandom_range(64)) - COORD_BITS'(32);
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	function automatic in_t random_particle(input logic last);
		logic [MASS_BITS-1:0] m;
		case ($urandom_range(9))
			0: m = '0;
			1: m = M_MAX;
			default: m = MASS_BITS'($urandom);
		endcase
		return particle(m, random_coord(), random_coord(), random_coord(),
			random_coord(), random_coord(), random_coord(), last);
	endfunction

	task automatic test_directed();
		send_particle(particle('0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1));
		send_particle(particle(M_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1));
		send_particle(particle(M_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 1'b1));
		send_particle(particle(M_MAX, '0, C_MIN, C_MAX, '0, C_MIN, C_MIN, 1'b1));
		send_particle(particle(M_MAX, C_MIN, C_MAX, '0, C_MAX, C_MAX, C_MIN, 1'b1));
		// no displacement
		send_particle(particle(M_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, 1'b1));
		send_particle(particle(MASS_BITS'(1), COORD_BITS'(1), COORD_BITS'(-1),
			COORD_BITS'(1), COORD_BITS'(-1), COORD_BITS'(1), COORD_BITS'(-1), 1'b1));
		send_particle(particle(M_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 1'b0));
		send_particle(particle('0, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 1'b0));
		send_particle(particle(M_MAX, C_MIN, '0, C_MAX, C_MAX, C_MIN, '0, 1'b0));
		send_particle(particle(M_MAX, '0, C_MAX, C_MIN, C_MIN, '0, C_MAX, 1'b1));
		drain();
	endtask

	task automatic test_random_sets(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				send_particle(random_particle(1'($urandom_range(1))));
				sent++;
			end else begin
				len = ($urandom_range(15) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1);
				for (int k = 1; k <= len; k++)
					send_particle(random_particle(k == len));
				sent += len;
			end
		end
		send_particle(random_particle(1'b1));
		drain();
	endtask

	task automatic test_result_stall();
		stall_request = STALL_CYCLES;
		for (int k = 0; k < 40; k++)
			send_particle(random_particle(1'b1));
		drain();
	endtask

	// one long set of largest squared displacements drives the energy sum to its top
	task automatic test_saturation();
		in_t big;
		big = particle(M_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b0);
		for (int k = 1; k <= SAT_SET_LEN; k++) begin
			big.is_last = (k == SAT_SET_LEN);
			send_particle(big);
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		clear_sums();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 8;
		recv_idle_pct = 60;
		test_directed();
		test_random_sets(200);
		test_result_stall();
		send_idle_pct = 60;
		recv_idle_pct = 8;
		test_random_sets(200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_sets(150);
		test_saturation();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && sums_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
